FILE: sv/tlc_pkg.sv
// Package: sizes, request and outcome codes, entry and control types for the lookup cache.
package tlc_pkg;

   localparam int unsigned FIRST_DEPTH  = 1024;
   localparam int unsigned SECOND_DEPTH = 512;
   localparam int unsigned ENTRY_BYTES  = 16;

   localparam int unsigned FIRST_AW  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
   localparam int unsigned SECOND_AW = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;

   // clearing pass covers the deeper of the two levels
   localparam int unsigned CLR_LEN = (FIRST_DEPTH > SECOND_DEPTH) ? FIRST_DEPTH : SECOND_DEPTH;
   localparam int unsigned CLR_AW  = $clog2(CLR_LEN);

   // request codes
   localparam logic [2:0] REQ_LOOKUP    = 3'd0;
   localparam logic [2:0] REQ_PROBE     = 3'd1;
   localparam logic [2:0] REQ_FILL      = 3'd2;
   localparam logic [2:0] REQ_FLUSH_KEY = 3'd3;
   localparam logic [2:0] REQ_FLUSH_ALL = 3'd4;
   localparam logic [2:0] REQ_CLEAR_CNT = 3'd5;

   // outcome codes
   localparam logic [1:0] OUT_FIRST_HIT  = 2'd0;
   localparam logic [1:0] OUT_SECOND_HIT = 2'd1;
   localparam logic [1:0] OUT_MISS       = 2'd2;
   localparam logic [1:0] OUT_NONE       = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [31:0] cls;
      logic [31:0] sel;
      logic [31:0] res;
   } tlc_entry_type;

   typedef struct packed {
      logic              rd_en;
      logic              exec_en;
      logic              clr_en;
      logic [CLR_AW-1:0] clr_addr;
   } tlc_cmd_type;

   typedef struct packed {
      logic is_flush_all;
   } tlc_status_type;

   // first-level index: (class xor selector) per entry, modulo the depth
   function automatic logic [FIRST_AW-1:0] first_index(input logic [31:0] c,
                                                      input logic [31:0] k);
      logic [31:0] hash;
      hash = (c ^ k) / ENTRY_BYTES;
      return FIRST_AW'(hash % FIRST_DEPTH);
   endfunction

   // second-level index: first-level index modulo its own depth
   function automatic logic [SECOND_AW-1:0] second_index(input logic [FIRST_AW-1:0] pi);
      logic [31:0] w;
      w = 32'(pi);
      return SECOND_AW'(w % SECOND_DEPTH);
   endfunction

endpackage

FILE: sv/tlc_req_if.sv
// Interface: request channel of the lookup cache.
interface tlc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [31:0] key_class;
   logic [31:0] key_selector;
   logic [31:0] fill_result;

   modport source (output valid, req_type, key_class, key_selector, fill_result,
                   input ready);
   modport sink   (input valid, req_type, key_class, key_selector, fill_result,
                   output ready);
endinterface

FILE: sv/tlc_rsp_if.sv
// Interface: response channel of the lookup cache.
interface tlc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  outcome;
   logic [31:0] found_result;
   logic [31:0] first_hits_now;
   logic [31:0] second_hits_now;
   logic [31:0] misses_now;

   modport source (output valid, outcome, found_result, first_hits_now, second_hits_now,
                   misses_now, input ready);
   modport sink   (input valid, outcome, found_result, first_hits_now, second_hits_now,
                   misses_now, output ready);
endinterface

FILE: sv/tlc_datapath.sv
// Datapath: both cache levels, match and swap logic, hit and miss counters, response payload.
module tlc_datapath import tlc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tlc_cmd_type    cmd,
   output tlc_status_type status,
   input  logic [2:0]     req_type,
   input  logic [31:0]    key_class,
   input  logic [31:0]    key_selector,
   input  logic [31:0]    fill_result,
   output logic [1:0]     outcome,
   output logic [31:0]    found_result,
   output logic [31:0]    first_hits_now,
   output logic [31:0]    second_hits_now,
   output logic [31:0]    misses_now
);

   tlc_entry_type first_mem  [FIRST_DEPTH];
   tlc_entry_type second_mem [SECOND_DEPTH];

   tlc_entry_type        p_rd_ff, s_rd_ff;
   logic [2:0]           type_ff;
   logic [31:0]          class_ff, sel_ff, fill_ff;
   logic [FIRST_AW-1:0]  pi_ff, rd_pi;
   logic [SECOND_AW-1:0] si_ff, rd_si;

   logic [1:0]  outcome_ff, outcome_in;
   logic [31:0] found_ff, found_in;
   logic [31:0] first_hit_tally_ff, first_hit_tally_in;
   logic [31:0] second_hit_tally_ff, second_hit_tally_in;
   logic [31:0] miss_tally_ff, miss_tally_in;

   logic          p_match, s_match;
   logic          p_we, s_we, p_wen, s_wen;
   tlc_entry_type p_wd, s_wd, p_wdata, s_wdata;
   logic [FIRST_AW-1:0]  p_wa;
   logic [SECOND_AW-1:0] s_wa;

   assign rd_pi = first_index(key_class, key_selector);
   assign rd_si = second_index(rd_pi);

   // read both levels and capture the transaction when it is accepted
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         p_rd_ff  <= first_mem[rd_pi];
         s_rd_ff  <= second_mem[rd_si];
         type_ff  <= req_type;
         class_ff <= key_class;
         sel_ff   <= key_selector;
         fill_ff  <= fill_result;
         pi_ff    <= rd_pi;
         si_ff    <= rd_si;
      end
   end

   assign p_match = p_rd_ff.valid && (p_rd_ff.cls == class_ff) && (p_rd_ff.sel == sel_ff);
   assign s_match = s_rd_ff.valid && (s_rd_ff.cls == class_ff) && (s_rd_ff.sel == sel_ff);

   // decide write-back, outcome and counter updates for the held transaction
   always_comb begin
      p_we                = 1'b0;
      s_we                = 1'b0;
      p_wd                = p_rd_ff;
      s_wd                = s_rd_ff;
      outcome_in          = OUT_NONE;
      found_in            = 32'd0;
      first_hit_tally_in  = first_hit_tally_ff;
      second_hit_tally_in = second_hit_tally_ff;
      miss_tally_in       = miss_tally_ff;
      case (type_ff)
         REQ_LOOKUP, REQ_PROBE: begin
            if (p_match) begin
               outcome_in = OUT_FIRST_HIT;
               found_in   = p_rd_ff.res;
               if (type_ff == REQ_LOOKUP) first_hit_tally_in = first_hit_tally_ff + 32'd1;
            end else if (s_match) begin
               p_we       = 1'b1;
               s_we       = 1'b1;
               p_wd       = s_rd_ff;
               s_wd       = p_rd_ff;
               outcome_in = OUT_SECOND_HIT;
               found_in   = s_rd_ff.res;
               if (type_ff == REQ_LOOKUP) second_hit_tally_in = second_hit_tally_ff + 32'd1;
            end else begin
               outcome_in = OUT_MISS;
               if (type_ff == REQ_LOOKUP) miss_tally_in = miss_tally_ff + 32'd1;
            end
         end
         REQ_FILL: begin
            if (fill_ff != 32'd0) begin
               // demote the first entry, then install the new one
               s_we       = 1'b1;
               s_wd       = p_rd_ff;
               p_we       = 1'b1;
               p_wd.valid = 1'b1;
               p_wd.cls   = class_ff;
               p_wd.sel   = sel_ff;
               p_wd.res   = fill_ff;
            end
         end
         REQ_FLUSH_KEY: begin
            if (p_match) begin
               p_we       = 1'b1;
               p_wd       = s_rd_ff;
               s_we       = 1'b1;
               s_wd.valid = 1'b0;
            end else if (s_match) begin
               s_we       = 1'b1;
               s_wd.valid = 1'b0;
            end
         end
         REQ_FLUSH_ALL, REQ_CLEAR_CNT: begin
            first_hit_tally_in  = 32'd0;
            second_hit_tally_in = 32'd0;
            miss_tally_in       = 32'd0;
         end
         default: begin
         end
      endcase
   end

   // share each write port between the clearing pass and write-back
   assign p_wa    = cmd.clr_en ? cmd.clr_addr[FIRST_AW-1:0] : pi_ff;
   assign s_wa    = cmd.clr_en ? cmd.clr_addr[SECOND_AW-1:0] : si_ff;
   assign p_wen   = (cmd.clr_en && (32'(cmd.clr_addr) < FIRST_DEPTH)) || (cmd.exec_en && p_we);
   assign s_wen   = (cmd.clr_en && (32'(cmd.clr_addr) < SECOND_DEPTH)) || (cmd.exec_en && s_we);
   assign p_wdata = cmd.clr_en ? tlc_entry_type'('0) : p_wd;
   assign s_wdata = cmd.clr_en ? tlc_entry_type'('0) : s_wd;

   always_ff @(posedge clock) begin
      if (p_wen) first_mem[p_wa] <= p_wdata;
      if (s_wen) second_mem[s_wa] <= s_wdata;
   end

   // advance counters and load the response payload
   always_ff @(posedge clock) begin
      if (reset) begin
         first_hit_tally_ff  <= 32'd0;
         second_hit_tally_ff <= 32'd0;
         miss_tally_ff       <= 32'd0;
      end else if (cmd.exec_en) begin
         first_hit_tally_ff  <= first_hit_tally_in;
         second_hit_tally_ff <= second_hit_tally_in;
         miss_tally_ff       <= miss_tally_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec_en) begin
         outcome_ff <= outcome_in;
         found_ff   <= found_in;
      end
   end

   assign outcome             = outcome_ff;
   assign found_result        = found_ff;
   assign first_hits_now      = first_hit_tally_ff;
   assign second_hits_now     = second_hit_tally_ff;
   assign misses_now          = miss_tally_ff;
   assign status.is_flush_all = (type_ff == REQ_FLUSH_ALL);

endmodule

FILE: sv/tlc_controller.sv
// Controller: sequences accept, execute and the clearing pass, and owns the response valid.
module tlc_controller import tlc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output tlc_cmd_type    cmd,
   input  tlc_status_type status
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CLR_AW-1:0] clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept, out_free, clr_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign clr_last  = (clr_ff == CLR_AW'(CLR_LEN - 1));

   assign cmd.rd_en    = accept;
   assign cmd.exec_en  = (state_ff == ST_EXEC) && out_free;
   assign cmd.clr_en   = (state_ff == ST_CLEAR);
   assign cmd.clr_addr = clr_ff;

   // next state and clearing pointer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               if (status.is_flush_all) begin
                  state_in = ST_CLEAR;
                  clr_in   = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_CLEAR: begin
            if (clr_last) state_in = ST_IDLE;
            else clr_in = clr_ff + CLR_AW'(1);
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // hold the response until the receiver takes it
   always_comb begin
      if (cmd.exec_en) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: sv/two_level_lookup_cache.sv
// Two-level direct-mapped lookup cache with swap on second-level hit.
//
// Requests arrive on req_chan (valid/ready): a type code, a class word, a
// selector word and a fill result. Each accepted transaction yields exactly
// one response on rsp_chan: outcome, found result and the three running
// counters as they stand after the transaction.
// The response becomes valid when the transaction's execute step (the EXEC
// state) completes. Both levels are read in the accept cycle and written
// back in the execute step; the controller takes no new request until that
// step is done, so only one transaction is in the block at a time.
// A finished response waits in the output register; the next transaction is
// accepted meanwhile, and its write-back waits until the register is free.
// Reset starts a clearing pass over 1024 entries (the deeper level's depth),
// one entry per cycle; ready stays low until it ends. Flush all delivers its
// response, then runs the same pass before the next accept.
// A stalled receiver holds the response and its payload unchanged.
module two_level_lookup_cache import tlc_pkg::*; (
   input logic     clock,
   input logic     reset,
   tlc_req_if.sink req_chan,
   tlc_rsp_if.source rsp_chan
);

   tlc_cmd_type    cmd;
   tlc_status_type status;

   tlc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   tlc_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_type        (req_chan.req_type),
      .key_class       (req_chan.key_class),
      .key_selector    (req_chan.key_selector),
      .fill_result     (req_chan.fill_result),
      .outcome         (rsp_chan.outcome),
      .found_result    (rsp_chan.found_result),
      .first_hits_now  (rsp_chan.first_hits_now),
      .second_hits_now (rsp_chan.second_hits_now),
      .misses_now      (rsp_chan.misses_now)
   );

endmodule

FILE: sv/tlc_checker.sv
// Checker: port-level assertions for the lookup cache, bound to the top level.
module tlc_checker import tlc_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  outcome,
   input logic [31:0] found_result,
   input logic [31:0] first_hits_now,
   input logic [31:0] second_hits_now,
   input logic [31:0] misses_now
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(outcome) && $stable(found_result) &&
         $stable(first_hits_now) && $stable(second_hits_now) && $stable(misses_now))
      else $error("response payload changed while stalled");

   // clearing pass follows reset, so nothing is accepted right after it
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // one transaction at a time: no accept in the cycle after an accept
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back-to-back accept");

   // misses and non-lookups carry no result word
   a_no_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (outcome == OUT_MISS || outcome == OUT_NONE) |-> found_result == 32'd0)
      else $error("result word on a miss or non-lookup");

endmodule

bind two_level_lookup_cache tlc_checker u_tlc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .outcome         (rsp_chan.outcome),
   .found_result    (rsp_chan.found_result),
   .first_hits_now  (rsp_chan.first_hits_now),
   .second_hits_now (rsp_chan.second_hits_now),
   .misses_now      (rsp_chan.misses_now)
);
